/* rtl/cbc_pkg.sv */
// shared types, constants and helper functions of the cartridge bank controller
`default_nettype none

package cbc_pkg;

   // sizes of the banked windows
   localparam int ROM_BANK_BYTES = 16384;
   localparam int RAM_BANK_BYTES = 8192;
   localparam int RAM_BANKS_MAX  = 4;
   localparam int ROM_OFFSET_W   = $clog2(ROM_BANK_BYTES);
   localparam int RAM_OFFSET_W   = $clog2(RAM_BANK_BYTES);
   localparam int RAM_BANK_W     = $clog2(RAM_BANKS_MAX);
   localparam int RAM_DEPTH      = RAM_BANKS_MAX * RAM_BANK_BYTES;
   localparam int RAM_ADDR_W     = $clog2(RAM_DEPTH);
   localparam int ROM_INDEX_W    = 21;
   localparam int ROM_BANK_W     = ROM_INDEX_W - ROM_OFFSET_W;

   // configuration port
   localparam int CSR_INDEX_W = 4;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROM_BANK_BITS = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RAM_BANK_BITS = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HAS_RAM       = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_HAS_RTC       = 4'd3;

   // clock register selects
   localparam logic [7:0] SEL_SECONDS  = 8'h08;
   localparam logic [7:0] SEL_MINUTES  = 8'h09;
   localparam logic [7:0] SEL_HOURS    = 8'h0A;
   localparam logic [7:0] SEL_DAY_LOW  = 8'h0B;
   localparam logic [7:0] SEL_DAY_HIGH = 8'h0C;

   // clock limits
   localparam int SECONDS_PER_MINUTE = 60;
   localparam int MINUTES_PER_HOUR   = 60;
   localparam int HOURS_PER_DAY      = 24;
   localparam int DAYS_WRAP          = 512;

   // misc byte values
   localparam logic [7:0] OPEN_BUS_BYTE = 8'hFF;
   localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;
   localparam logic [7:0] LATCH_ARM_BYTE = 8'h00;
   localparam logic [7:0] LATCH_FIRE_BYTE = 8'h01;

   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_TICK  = 2'd2,
      OP_NOP   = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      KIND_OPEN = 2'd0,
      KIND_ROM  = 2'd1,
      KIND_DATA = 2'd2,
      KIND_NONE = 2'd3
   } kind_type;

   typedef struct packed {
      opcode_type  opcode;
      logic [15:0] bus_address;
      logic [7:0]  write_data;
   } req_type;

   typedef struct packed {
      kind_type               result_kind;
      logic [7:0]             read_data;
      logic [ROM_INDEX_W-1:0] rom_index;
      logic                   ram_was_written;
   } rsp_type;

   // clock counters, same layout as the latched copy
   typedef struct packed {
      logic       carry;
      logic       halt;
      logic [8:0] days;
      logic [4:0] hours;
      logic [5:0] minutes;
      logic [5:0] seconds;
   } rtc_time_type;

   typedef struct packed {
      logic tick;
      logic clock_write;
      logic latch;
   } rtc_cmd_type;

   function automatic logic sel_is_clock(input logic [7:0] sel);
      return (sel >= SEL_SECONDS) && (sel <= SEL_DAY_HIGH);
   endfunction

   // byte modulo 60 by restoring subtraction
   function automatic logic [7:0] mod60(input logic [7:0] x);
      logic [7:0] r;
      r = x;
      if (r >= 8'(4 * SECONDS_PER_MINUTE)) r = r - 8'(4 * SECONDS_PER_MINUTE);
      if (r >= 8'(2 * SECONDS_PER_MINUTE)) r = r - 8'(2 * SECONDS_PER_MINUTE);
      if (r >= 8'(SECONDS_PER_MINUTE)) r = r - 8'(SECONDS_PER_MINUTE);
      return r;
   endfunction

   // byte modulo 24 by restoring subtraction
   function automatic logic [7:0] mod24(input logic [7:0] x);
      logic [7:0] r;
      r = x;
      if (r >= 8'(8 * HOURS_PER_DAY)) r = r - 8'(8 * HOURS_PER_DAY);
      if (r >= 8'(4 * HOURS_PER_DAY)) r = r - 8'(4 * HOURS_PER_DAY);
      if (r >= 8'(2 * HOURS_PER_DAY)) r = r - 8'(2 * HOURS_PER_DAY);
      if (r >= 8'(HOURS_PER_DAY)) r = r - 8'(HOURS_PER_DAY);
      return r;
   endfunction

endpackage

`default_nettype wire

/* rtl/cbc_ram.sv */
// generic single-clock ram, one write port and one registered read port
`default_nettype none

module cbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // read data holds while no read is issued
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* rtl/cbc_rtc.sv */
// real-time clock counters, latch copy and register read/write
`default_nettype none

module cbc_rtc (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cbc_pkg::rtc_cmd_type cmd,
   input  wire logic [7:0]           sel,
   input  wire logic [7:0]           wdata,
   output logic      [7:0]           rd_byte
);

   cbc_pkg::rtc_time_type live_ff, live_in;
   cbc_pkg::rtc_time_type latched_ff, latched_in;
   logic                  latch_taken_ff, latch_taken_in;
   cbc_pkg::rtc_time_type view;
   logic [6:0]            sec_inc;
   logic [6:0]            min_inc;
   logic [5:0]            hour_inc;
   logic [9:0]            day_inc;
   logic [7:0]            sec_mod;
   logic [7:0]            min_mod;
   logic [7:0]            hour_mod;
   logic [7:0]            wr_mod60;
   logic [7:0]            wr_mod24;

   // read side: latched copy once any latch was taken
   always_comb begin
      view     = latch_taken_ff ? latched_ff : live_ff;
      sec_mod  = cbc_pkg::mod60({2'b00, view.seconds});
      min_mod  = cbc_pkg::mod60({2'b00, view.minutes});
      hour_mod = cbc_pkg::mod24({3'b000, view.hours});
      case (sel)
         cbc_pkg::SEL_SECONDS: rd_byte = sec_mod;
         cbc_pkg::SEL_MINUTES: rd_byte = min_mod;
         cbc_pkg::SEL_HOURS:   rd_byte = hour_mod;
         cbc_pkg::SEL_DAY_LOW: rd_byte = view.days[7:0];
         default:              rd_byte = {view.carry, view.halt, 5'b00000, view.days[8]};
      endcase
   end

   // next state of the live counters
   always_comb begin
      live_in  = live_ff;
      sec_inc  = {1'b0, live_ff.seconds} + 7'd1;
      min_inc  = {1'b0, live_ff.minutes} + 7'd1;
      hour_inc = {1'b0, live_ff.hours} + 6'd1;
      day_inc  = {1'b0, live_ff.days} + 10'd1;
      wr_mod60 = cbc_pkg::mod60(wdata);
      wr_mod24 = cbc_pkg::mod24(wdata);
      if (cmd.tick && !live_ff.halt) begin
         // ripple carry through seconds, minutes, hours and days
         if (sec_inc < 7'(cbc_pkg::SECONDS_PER_MINUTE)) begin
            live_in.seconds = sec_inc[5:0];
         end else begin
            live_in.seconds = '0;
            if (min_inc < 7'(cbc_pkg::MINUTES_PER_HOUR)) begin
               live_in.minutes = min_inc[5:0];
            end else begin
               live_in.minutes = '0;
               if (hour_inc < 6'(cbc_pkg::HOURS_PER_DAY)) begin
                  live_in.hours = hour_inc[4:0];
               end else begin
                  live_in.hours = '0;
                  if (day_inc >= 10'(cbc_pkg::DAYS_WRAP)) begin
                     live_in.days  = '0;
                     live_in.carry = 1'b1;
                  end else begin
                     live_in.days = day_inc[8:0];
                  end
               end
            end
         end
      end else if (cmd.clock_write) begin
         case (sel)
            cbc_pkg::SEL_SECONDS: live_in.seconds = wr_mod60[5:0];
            cbc_pkg::SEL_MINUTES: live_in.minutes = wr_mod60[5:0];
            cbc_pkg::SEL_HOURS:   live_in.hours   = wr_mod24[4:0];
            cbc_pkg::SEL_DAY_LOW: live_in.days    = {live_ff.days[8], wdata};
            default: begin
               live_in.days  = {wdata[0], live_ff.days[7:0]};
               live_in.halt  = wdata[6];
               live_in.carry = wdata[7];
            end
         endcase
      end
   end

   // latch copy
   always_comb begin
      latched_in     = latched_ff;
      latch_taken_in = latch_taken_ff;
      if (cmd.latch) begin
         latched_in     = live_ff;
         latch_taken_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff        <= '0;
         latched_ff     <= '0;
         latch_taken_ff <= 1'b0;
      end else begin
         live_ff        <= live_in;
         latched_ff     <= latched_in;
         latch_taken_ff <= latch_taken_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/cbc_ctrl.sv */
// configuration and bank registers, address decode and ram access setup
`default_nettype none

module cbc_ctrl (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write,
   input  wire logic [cbc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [7:0]                          csr_data,
   input  wire logic                                accept,
   input  wire cbc_pkg::req_type                    req,
   input  wire logic [7:0]                          rtc_rd_byte,
   output cbc_pkg::rtc_cmd_type                     rtc_cmd,
   output logic      [7:0]                          rtc_sel,
   output logic                                     ram_we,
   output logic                                     ram_re,
   output logic      [cbc_pkg::RAM_ADDR_W-1:0]      ram_addr,
   output cbc_pkg::rsp_type                         draft,
   output logic                                     need_ram
);

   logic [2:0] rom_bank_bits_ff;
   logic [1:0] ram_bank_bits_ff;
   logic       has_ram_ff;
   logic       has_rtc_ff;
   logic       ram_enable_ff, ram_enable_in;
   logic [6:0] rom_bank_ff, rom_bank_in;
   logic [7:0] bank_sel_ff, bank_sel_in;
   logic [7:0] latch_byte_ff, latch_byte_in;

   logic [15:0]                       addr;
   logic [7:0]                        wdat;
   logic                              in_ram_win;
   logic                              sel_clock;
   logic [6:0]                        rom_mask;
   logic [6:0]                        rom_bank_eff;
   logic [6:0]                        rom_bank_m;
   logic                              rom_bank_ok;
   logic [1:0]                        ram_bits_eff;
   logic [cbc_pkg::RAM_BANK_W-1:0]    ram_mask;
   logic [cbc_pkg::RAM_BANK_W-1:0]    ram_bank;
   cbc_pkg::rtc_cmd_type              cmd;
   logic                              ram_hit;
   logic                              ram_wr_hit;

   assign addr    = req.bus_address;
   assign wdat    = req.write_data;
   assign rtc_sel = bank_sel_ff;

   // bank arithmetic
   always_comb begin
      in_ram_win   = (addr[15:13] == 3'b101);
      sel_clock    = cbc_pkg::sel_is_clock(bank_sel_ff);
      rom_mask     = 7'((8'd1 << rom_bank_bits_ff) - 8'd1);
      rom_bank_eff = (rom_bank_ff == 7'd0) ? 7'd1 : rom_bank_ff;
      rom_bank_m   = rom_bank_eff & rom_mask;
      if (rom_bank_m == 7'd0) begin
         rom_bank_m = 7'd1;
      end
      // with a single bank the banked window is open bus
      rom_bank_ok  = (rom_bank_bits_ff != 3'd0);
      ram_bits_eff = (ram_bank_bits_ff > 2'd2) ? 2'd2 : ram_bank_bits_ff;
      ram_mask     = cbc_pkg::RAM_BANK_W'((3'd1 << ram_bits_eff) - 3'd1);
      ram_bank     = bank_sel_ff[cbc_pkg::RAM_BANK_W-1:0] & ram_mask;
      ram_addr     = {ram_bank, addr[cbc_pkg::RAM_OFFSET_W-1:0]};
   end

   // decode of one item
   always_comb begin
      draft.result_kind     = cbc_pkg::KIND_NONE;
      draft.read_data       = 8'h00;
      draft.rom_index       = '0;
      draft.ram_was_written = 1'b0;
      cmd                   = '0;
      ram_hit               = 1'b0;
      ram_wr_hit            = 1'b0;
      ram_enable_in         = ram_enable_ff;
      rom_bank_in           = rom_bank_ff;
      bank_sel_in           = bank_sel_ff;
      latch_byte_in         = latch_byte_ff;
      case (req.opcode)
         cbc_pkg::OP_READ: begin
            draft.result_kind = cbc_pkg::KIND_OPEN;
            draft.read_data   = cbc_pkg::OPEN_BUS_BYTE;
            if (addr[15:14] == 2'b00) begin
               draft.result_kind = cbc_pkg::KIND_ROM;
               draft.read_data   = 8'h00;
               draft.rom_index   = {{cbc_pkg::ROM_BANK_W{1'b0}},
                                    addr[cbc_pkg::ROM_OFFSET_W-1:0]};
            end else if (addr[15:14] == 2'b01) begin
               if (rom_bank_ok) begin
                  draft.result_kind = cbc_pkg::KIND_ROM;
                  draft.read_data   = 8'h00;
                  draft.rom_index   = {rom_bank_m, addr[cbc_pkg::ROM_OFFSET_W-1:0]};
               end
            end else if (in_ram_win && ram_enable_ff) begin
               if (sel_clock) begin
                  if (has_rtc_ff) begin
                     draft.result_kind = cbc_pkg::KIND_DATA;
                     draft.read_data   = rtc_rd_byte;
                  end
               end else if (has_ram_ff) begin
                  // byte filled in from the ram read data in the middle stage
                  draft.result_kind = cbc_pkg::KIND_DATA;
                  draft.read_data   = 8'h00;
                  ram_hit           = 1'b1;
               end
            end
         end
         cbc_pkg::OP_WRITE: begin
            case (addr[15:13])
               3'b000: ram_enable_in = (wdat[3:0] == cbc_pkg::RAM_ENABLE_KEY);
               3'b001: rom_bank_in   = (wdat[6:0] == 7'd0) ? 7'd1 : wdat[6:0];
               3'b010: bank_sel_in   = wdat;
               3'b011: begin
                  latch_byte_in = wdat;
                  cmd.latch     = has_rtc_ff && (latch_byte_ff == cbc_pkg::LATCH_ARM_BYTE)
                                  && (wdat == cbc_pkg::LATCH_FIRE_BYTE);
               end
               3'b101: begin
                  if (ram_enable_ff) begin
                     if (sel_clock) begin
                        cmd.clock_write = has_rtc_ff;
                     end else if (has_ram_ff) begin
                        ram_wr_hit            = 1'b1;
                        draft.ram_was_written = 1'b1;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         cbc_pkg::OP_TICK: cmd.tick = has_rtc_ff;
         default: begin
         end
      endcase
   end

   // side effects only on an accepted item
   always_comb begin
      rtc_cmd  = accept ? cmd : '0;
      ram_we   = accept && ram_wr_hit;
      ram_re   = accept && ram_hit;
      need_ram = ram_hit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rom_bank_bits_ff <= 3'd7;
         ram_bank_bits_ff <= 2'd2;
         has_ram_ff       <= 1'b1;
         has_rtc_ff       <= 1'b1;
         ram_enable_ff    <= 1'b0;
         rom_bank_ff      <= 7'd1;
         bank_sel_ff      <= 8'h00;
         latch_byte_ff    <= 8'h00;
      end else begin
         if (csr_write) begin
            case (csr_index)
               cbc_pkg::CSR_ROM_BANK_BITS: rom_bank_bits_ff <= csr_data[2:0];
               cbc_pkg::CSR_RAM_BANK_BITS: ram_bank_bits_ff <= csr_data[1:0];
               cbc_pkg::CSR_HAS_RAM:       has_ram_ff       <= csr_data[0];
               cbc_pkg::CSR_HAS_RTC:       has_rtc_ff       <= csr_data[0];
               default: begin
               end
            endcase
         end
         if (accept) begin
            ram_enable_ff <= ram_enable_in;
            rom_bank_ff   <= rom_bank_in;
            bank_sel_ff   <= bank_sel_in;
            latch_byte_ff <= latch_byte_in;
         end
      end
   end

endmodule

`default_nettype wire

/* rtl/cartridge_bank_controller_rtc_unit.sv */
// top level of the cartridge bank controller with real-time clock
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    req_data  (cbc_pkg::req_type)
//   rsp      out        rsp_valid/rsp_ready    rsp_data  (cbc_pkg::rsp_type)
//   csr      in         csr_valid/csr_ready    csr_index, csr_data
//
// one item is accepted per cycle while req_ready is high; its result passes through the
// middle stage, where the registered ram read completes, and then the output register
// the result path is a two-entry pipeline, so the next item is taken while a result
// waits; req_ready drops only while both the middle stage and output register are full
// synchronous active-high reset clears control registers and clock counters; the ram
// has no reset and is valid only where written, so no clearing pass is run
`default_nettype none

module cartridge_bank_controller_rtc_unit (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire cbc_pkg::req_type                req_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output cbc_pkg::rsp_type                     rsp_data,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [cbc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [7:0]                      csr_data
);

   logic                            accept;
   logic                            s1_move;
   logic                            s1_valid_ff, s1_valid_in;
   cbc_pkg::rsp_type                s1_data_ff, s1_data_in;
   logic                            s1_ram_ff, s1_ram_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   cbc_pkg::rsp_type                rsp_data_ff, rsp_data_in;
   cbc_pkg::rsp_type                merged;
   cbc_pkg::rtc_cmd_type            rtc_cmd;
   logic [7:0]                      rtc_sel;
   logic [7:0]                      rtc_rd_byte;
   logic                            ram_we;
   logic                            ram_re;
   logic [cbc_pkg::RAM_ADDR_W-1:0]  ram_addr;
   logic [7:0]                      ram_rdata;
   cbc_pkg::rsp_type                draft;
   logic                            need_ram;

   // handshake
   assign csr_ready = 1'b1;
   assign s1_move   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_move;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   cbc_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_write   (csr_valid && csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .accept      (accept),
      .req         (req_data),
      .rtc_rd_byte (rtc_rd_byte),
      .rtc_cmd     (rtc_cmd),
      .rtc_sel     (rtc_sel),
      .ram_we      (ram_we),
      .ram_re      (ram_re),
      .ram_addr    (ram_addr),
      .draft       (draft),
      .need_ram    (need_ram)
   );

   cbc_rtc u_rtc (
      .clock   (clock),
      .reset   (reset),
      .cmd     (rtc_cmd),
      .sel     (rtc_sel),
      .wdata   (req_data.write_data),
      .rd_byte (rtc_rd_byte)
   );

   cbc_ram #(
      .WIDTH (8),
      .DEPTH (cbc_pkg::RAM_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_addr),
      .wr_data (req_data.write_data),
      .rd_en   (ram_re),
      .rd_addr (ram_addr),
      .rd_data (ram_rdata)
   );

   // middle stage waits for the ram byte
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_data_in  = s1_data_ff;
      s1_ram_in   = s1_ram_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
         s1_data_in  = draft;
         s1_ram_in   = need_ram;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
   end

   // output register, ram byte merged in on the way
   always_comb begin
      merged = s1_data_ff;
      if (s1_ram_ff) begin
         merged.read_data = ram_rdata;
      end
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (s1_move) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = merged;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s1_data_ff  <= s1_data_in;
      s1_ram_ff   <= s1_ram_in;
      rsp_data_ff <= rsp_data_in;
   end

   // ram read item lands in the middle stage flagged for the ram byte
   a_ram_read_tracked: assert property (@(posedge clock) disable iff (reset)
      accept && need_ram |=> s1_valid_ff && s1_ram_ff)
      else $error("ram read item not tracked in middle stage");

   // a stalled middle stage keeps its item and blocks new ones
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_move |=> s1_valid_ff && $stable(s1_data_ff) && $stable(ram_rdata))
      else $error("middle stage lost its item while stalled");

   a_no_accept_stalled: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_move |-> !req_ready)
      else $error("item accepted over a stalled middle stage");

   // ram sees one access per item
   a_ram_one_access: assert property (@(posedge clock) disable iff (reset)
      !(ram_we && ram_re))
      else $error("ram read and write issued together");

endmodule

`default_nettype wire

/* tb/sv/tb_cartridge_bank_controller_rtc_unit.sv */
`timescale 1ns / 1ps
// self-checking testbench of the cartridge bank controller with real-time clock
module tb_cartridge_bank_controller_rtc_unit;
   import cbc_pkg::*;

   // cpu address map of the cartridge
   localparam logic [15:0] REG_ENABLE_END = 16'h1FFF;
   localparam logic [15:0] FIXED_ROM_END  = 16'h3FFF;  // also end of the rom bank register
   localparam logic [15:0] REG_SELECT_END = 16'h5FFF;
   localparam logic [15:0] BANKED_ROM_END = 16'h7FFF;  // also end of the latch register
   localparam logic [15:0] WINDOW_BASE    = 16'hA000;
   localparam logic [15:0] WINDOW_END     = 16'hBFFF;

   localparam int SEEDED_PER_END  = 8;   // bytes written at each end of every ram bank
   localparam int ITEMS_PER_PHASE = 135;
   localparam int PHASES          = 7;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [7:0]             csr_data  = '0;

   cartridge_bank_controller_rtc_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // bus cycles waiting to be sent and replies the cartridge still owes
   req_type bus_cycles_todo[$];
   rsp_type bus_replies_due[$];
   int      queued      = 0;
   int      bad_replies = 0;
   bit      idle_on     = 1'b1;
   int      send_gap    = 0;
   int      recv_stall  = 0;
   rsp_type due;

   // cartridge state as the testbench sees it
   logic [2:0]   rom_bits_cfg;
   logic [1:0]   ram_bits_cfg;
   logic         ram_fitted;
   logic         rtc_fitted;
   logic         ram_on;
   logic [6:0]   rom_bank;
   logic [7:0]   bank_select;
   logic [7:0]   last_latch_byte;
   rtc_time_type live_time;
   rtc_time_type held_time;
   logic         held_valid;
   logic [7:0]   ram_image [RAM_DEPTH];

   task automatic reset_cartridge_model();
      rom_bits_cfg    = 3'd7;
      ram_bits_cfg    = 2'd2;
      ram_fitted      = 1'b1;
      rtc_fitted      = 1'b1;
      ram_on          = 1'b0;
      rom_bank        = 7'd1;
      bank_select     = '0;
      last_latch_byte = '0;
      live_time       = '0;
      held_time       = '0;
      held_valid      = 1'b0;
   endtask

   task automatic apply_setting(input logic [CSR_INDEX_W-1:0] idx, input logic [7:0] val);
      case (idx)
         CSR_ROM_BANK_BITS: rom_bits_cfg = val[2:0];
         CSR_RAM_BANK_BITS: ram_bits_cfg = val[1:0];
         CSR_HAS_RAM:       ram_fitted   = val[0];
         CSR_HAS_RTC:       rtc_fitted   = val[0];
         default: ;
      endcase
   endtask

   // byte address in the ram image, bank taken modulo the fitted bank count
   function automatic int ram_byte_addr(input logic [15:0] addr);
      int banks;
      banks = 1 << ((ram_bits_cfg > 2'd2) ? 2 : int'(ram_bits_cfg));
      return (int'(bank_select[1:0]) % banks) * RAM_BANK_BYTES +
             int'(addr[RAM_OFFSET_W-1:0]);
   endfunction

   // clock register as read through the window, latched copy once a latch was taken
   function automatic logic [7:0] clock_byte();
      rtc_time_type t;
      t = held_valid ? held_time : live_time;
      case (bank_select)
         SEL_SECONDS: return 8'(int'(t.seconds) % SECONDS_PER_MINUTE);
         SEL_MINUTES: return 8'(int'(t.minutes) % MINUTES_PER_HOUR);
         SEL_HOURS:   return 8'(int'(t.hours) % HOURS_PER_DAY);
         SEL_DAY_LOW: return t.days[7:0];
         default:     return {t.carry, t.halt, 5'b0, t.days[8]};
      endcase
   endfunction

   task automatic set_clock_field(input logic [7:0] v);
      case (bank_select)
         SEL_SECONDS: live_time.seconds = 6'(int'(v) % SECONDS_PER_MINUTE);
         SEL_MINUTES: live_time.minutes = 6'(int'(v) % MINUTES_PER_HOUR);
         SEL_HOURS:   live_time.hours   = 5'(int'(v) % HOURS_PER_DAY);
         SEL_DAY_LOW: live_time.days[7:0] = v;
         default: begin
            live_time.days[8] = v[0];
            live_time.halt    = v[6];
            live_time.carry   = v[7];
         end
      endcase
   endtask

   // one second, rolling over into minutes, hours and the 9-bit day count
   task automatic advance_clock();
      if (rtc_fitted && !live_time.halt) begin
         if (int'(live_time.seconds) + 1 < SECONDS_PER_MINUTE) begin
            live_time.seconds += 1;
         end else begin
            live_time.seconds = '0;
            if (int'(live_time.minutes) + 1 < MINUTES_PER_HOUR) begin
               live_time.minutes += 1;
            end else begin
               live_time.minutes = '0;
               if (int'(live_time.hours) + 1 < HOURS_PER_DAY) begin
                  live_time.hours += 1;
               end else begin
                  live_time.hours = '0;
                  if (int'(live_time.days) + 1 < DAYS_WRAP) begin
                     live_time.days += 1;
                  end else begin
                     live_time.days  = '0;
                     live_time.carry = 1'b1;
                  end
               end
            end
         end
      end
   endtask

   // work out the reply to one bus cycle and update the cartridge state
   task automatic run_cartridge_cycle(input req_type rq);
      rsp_type    r;
      logic [15:0] a;
      logic [7:0]  v;
      logic        on_clock;
      logic        in_window;
      int          banks;
      int          b;
      r.result_kind     = KIND_NONE;
      r.read_data       = '0;
      r.rom_index       = '0;
      r.ram_was_written = 1'b0;
      a         = rq.bus_address;
      v         = rq.write_data;
      on_clock  = (bank_select >= SEL_SECONDS) && (bank_select <= SEL_DAY_HIGH);
      in_window = (a >= WINDOW_BASE) && (a <= WINDOW_END) && ram_on;
      case (rq.opcode)
         OP_READ: begin
            r.result_kind = KIND_OPEN;
            r.read_data   = OPEN_BUS_BYTE;
            if (a <= FIXED_ROM_END) begin
               r.result_kind = KIND_ROM;
               r.read_data   = '0;
               r.rom_index   = ROM_INDEX_W'(a);
            end else if (a <= BANKED_ROM_END) begin
               // bank zero maps to one, also after masking; a one-bank rom reads open bus
               banks = 1 << rom_bits_cfg;
               b = (rom_bank == 7'd0) ? 1 : int'(rom_bank);
               b = b & (banks - 1);
               if (b == 0) b = 1;
               if (b < banks) begin
                  r.result_kind = KIND_ROM;
                  r.read_data   = '0;
                  r.rom_index   = ROM_INDEX_W'(b * ROM_BANK_BYTES +
                                               int'(a[ROM_OFFSET_W-1:0]));
               end
            end else if (in_window) begin
               if (on_clock) begin
                  if (rtc_fitted) begin
                     r.result_kind = KIND_DATA;
                     r.read_data   = clock_byte();
                  end
               end else if (ram_fitted) begin
                  r.result_kind = KIND_DATA;
                  r.read_data   = ram_image[ram_byte_addr(a)];
               end
            end
         end
         OP_WRITE: begin
            if (a <= REG_ENABLE_END) begin
               ram_on = (v[3:0] == RAM_ENABLE_KEY);
            end else if (a <= FIXED_ROM_END) begin
               rom_bank = v[6:0];
               if (rom_bank == 7'd0) rom_bank = 7'd1;
            end else if (a <= REG_SELECT_END) begin
               bank_select = v;
            end else if (a <= BANKED_ROM_END) begin
               // latch on the fire byte right after the arm byte
               if (rtc_fitted && last_latch_byte == LATCH_ARM_BYTE && v == LATCH_FIRE_BYTE) begin
                  held_time  = live_time;
                  held_valid = 1'b1;
               end
               last_latch_byte = v;
            end else if (in_window) begin
               if (on_clock) begin
                  if (rtc_fitted) set_clock_field(v);
               end else if (ram_fitted) begin
                  ram_image[ram_byte_addr(a)] = v;
                  r.ram_was_written = 1'b1;
               end
            end
         end
         OP_TICK: advance_clock();
         default: ;
      endcase
      bus_replies_due.push_back(r);
   endtask

   // gap length: mostly none or short, now and then long
   function automatic int pick_idle();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // sender: one item per handshake, random gaps between items
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready) run_cartridge_cycle(req_data);
         if (req_valid && !req_ready) begin
            // hold the item until taken
         end else if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (bus_cycles_todo.size() > 0) begin
            req_data  <= bus_cycles_todo.pop_front();
            req_valid <= 1'b1;
            send_gap = idle_on ? pick_idle() : 0;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   task automatic report_mismatch(input string field, input logic [31:0] want,
                                  input logic [31:0] got);
      bad_replies++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
   endtask

   // receiver: compare each reply with the oldest one due, random stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_stall = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (bus_replies_due.size() == 0) begin
               report_mismatch("unexpected reply", '0, rsp_data);
            end else begin
               due = bus_replies_due.pop_front();
               if (rsp_data.result_kind !== due.result_kind)
                  report_mismatch("result_kind", due.result_kind, rsp_data.result_kind);
               if (rsp_data.read_data !== due.read_data)
                  report_mismatch("read_data", due.read_data, rsp_data.read_data);
               if (rsp_data.rom_index !== due.rom_index)
                  report_mismatch("rom_index", due.rom_index, rsp_data.rom_index);
               if (rsp_data.ram_was_written !== due.ram_was_written)
                  report_mismatch("ram_was_written", due.ram_was_written,
                                  rsp_data.ram_was_written);
            end
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (idle_on && $urandom_range(0, 99) < 15) recv_stall = pick_idle();
         end
      end
   end

   // queue one bus cycle; window reads stay on bytes known to be written
   task automatic push_req(input opcode_type op, input logic [15:0] addr,
                           input logic [7:0] data);
      req_type     rq;
      logic [12:0] off;
      off = addr[RAM_OFFSET_W-1:0];
      if (op == OP_READ && addr >= WINDOW_BASE && addr <= WINDOW_END &&
          off >= SEEDED_PER_END && off < RAM_BANK_BYTES - SEEDED_PER_END)
         addr[RAM_OFFSET_W-1:0] = {addr[RAM_OFFSET_W-1] ? 10'h3FF : 10'h000, addr[2:0]};
      rq.opcode      = op;
      rq.bus_address = addr;
      rq.write_data  = data;
      bus_cycles_todo.push_back(rq);
      queued++;
   endtask

   function automatic logic [15:0] window_addr();
      return WINDOW_BASE | 16'($urandom_range(0, RAM_BANK_BYTES - 1));
   endfunction

   function automatic logic [15:0] seeded_window_addr();
      int k;
      k = $urandom_range(0, 2 * SEEDED_PER_END - 1);
      if (k >= SEEDED_PER_END) k = RAM_BANK_BYTES - 2 * SEEDED_PER_END + k;
      return WINDOW_BASE | 16'(k);
   endfunction

   function automatic logic [15:0] range_addr(input logic [15:0] lo, input logic [15:0] hi);
      return 16'($urandom_range(lo, hi));
   endfunction

   task automatic set_clock_reg(input logic [7:0] sel, input logic [7:0] v);
      push_req(OP_WRITE, range_addr(FIXED_ROM_END + 1, REG_SELECT_END), sel);
      push_req(OP_WRITE, window_addr(), v);
   endtask

   task automatic latch_clock();
      push_req(OP_WRITE, range_addr(REG_SELECT_END + 1, BANKED_ROM_END), LATCH_ARM_BYTE);
      push_req(OP_WRITE, range_addr(REG_SELECT_END + 1, BANKED_ROM_END), LATCH_FIRE_BYTE);
   endtask

   task automatic wait_drained();
      while (bus_cycles_todo.size() != 0 || bus_replies_due.size() != 0 || req_valid)
         @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [7:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      apply_setting(idx, val);
   endtask

   // every register, unused bits of the data random, plus one unused index
   task automatic load_settings(input int rom_bits, input int ram_bits, input int with_ram,
                                input int with_rtc);
      write_csr(CSR_INDEX_W'($urandom_range(int'(CSR_HAS_RTC) + 1, (1 << CSR_INDEX_W) - 1)),
                8'($urandom));
      write_csr(CSR_ROM_BANK_BITS, 8'(($urandom_range(0, 31) << 3) | rom_bits));
      write_csr(CSR_RAM_BANK_BITS, 8'(($urandom_range(0, 63) << 2) | ram_bits));
      write_csr(CSR_HAS_RAM, 8'(($urandom_range(0, 127) << 1) | with_ram));
      write_csr(CSR_HAS_RTC, 8'(($urandom_range(0, 127) << 1) | with_rtc));
   endtask

   // write both ends of every ram bank so later reads never hit unwritten bytes
   task automatic seed_ram();
      push_req(OP_WRITE, 16'h0000, {4'h0, RAM_ENABLE_KEY});
      for (int bank = 0; bank < RAM_BANKS_MAX; bank++) begin
         push_req(OP_WRITE, FIXED_ROM_END + 1, 8'(bank));
         for (int k = 0; k < SEEDED_PER_END; k++) begin
            push_req(OP_WRITE, WINDOW_BASE | 16'(k), 8'($urandom));
            push_req(OP_WRITE, WINDOW_BASE | 16'(RAM_BANK_BYTES - SEEDED_PER_END + k),
                     8'($urandom));
         end
      end
   endtask

   // rom extremes, bank zero, open bus, halt, day wrap with carry, latch
   task automatic directed_items();
      push_req(OP_READ, 16'h0000, 8'h00);
      push_req(OP_READ, FIXED_ROM_END, 8'hFF);
      push_req(OP_WRITE, FIXED_ROM_END - REG_ENABLE_END, 8'h00);
      push_req(OP_READ, FIXED_ROM_END + 1, 8'h00);
      push_req(OP_WRITE, FIXED_ROM_END, 8'hFF);
      push_req(OP_READ, BANKED_ROM_END, 8'h00);
      push_req(OP_WRITE, 16'h0000, 8'h00);
      push_req(OP_READ, WINDOW_BASE, 8'h00);
      push_req(OP_WRITE, REG_ENABLE_END, {4'h1, RAM_ENABLE_KEY});
      push_req(OP_READ, WINDOW_BASE - 1, 8'h00);
      push_req(OP_READ, 16'hFFFF, 8'h00);
      push_req(OP_NOP, 16'hFFFF, 8'hFF);
      set_clock_reg(SEL_DAY_HIGH, 8'hC1);
      push_req(OP_TICK, 16'h0000, 8'h00);
      push_req(OP_WRITE, WINDOW_END, 8'h01);
      set_clock_reg(SEL_DAY_LOW, 8'hFF);
      set_clock_reg(SEL_HOURS, 8'h2F);
      set_clock_reg(SEL_MINUTES, 8'h77);
      set_clock_reg(SEL_SECONDS, 8'hEF);
      push_req(OP_TICK, 16'hFFFF, 8'hFF);
      latch_clock();
      set_clock_reg(SEL_DAY_HIGH, 8'h00);
      push_req(OP_READ, WINDOW_END, 8'h00);
   endtask

   // set the clock close to a rollover, tick, latch and read it back
   task automatic clock_rollover_sequence();
      push_req(OP_WRITE, range_addr(16'h0000, REG_ENABLE_END), {4'($urandom), RAM_ENABLE_KEY});
      // halt mostly cleared so the ticks count
      set_clock_reg(SEL_DAY_HIGH, 8'($urandom) & (($urandom_range(0, 3) == 0) ? 8'hFF : 8'hBF));
      set_clock_reg(SEL_DAY_LOW, $urandom_range(0, 1) ? 8'hFF : 8'($urandom));
      set_clock_reg(SEL_HOURS, $urandom_range(0, 1) ? 8'(HOURS_PER_DAY - 1) : 8'($urandom));
      set_clock_reg(SEL_MINUTES,
                    $urandom_range(0, 1) ? 8'(MINUTES_PER_HOUR - 1) : 8'($urandom));
      set_clock_reg(SEL_SECONDS,
                    $urandom_range(0, 3) != 0 ?
                       8'($urandom_range(SECONDS_PER_MINUTE - 3, SECONDS_PER_MINUTE - 1)) :
                       8'($urandom));
      repeat ($urandom_range(1, 6)) push_req(OP_TICK, 16'($urandom), 8'($urandom));
      latch_clock();
      repeat ($urandom_range(1, 3)) begin
         push_req(OP_WRITE, range_addr(FIXED_ROM_END + 1, REG_SELECT_END),
                  8'($urandom_range(SEL_SECONDS, SEL_DAY_HIGH)));
         push_req(OP_READ, seeded_window_addr(), 8'($urandom));
      end
   endtask

   task automatic random_traffic(input int goal);
      int r;
      int s;
      goal = queued + goal;
      while (queued < goal) begin
         r = $urandom_range(0, 99);
         if (r < 20) begin
            push_req(OP_READ, range_addr(16'h0000, BANKED_ROM_END), 8'($urandom));
         end else if (r < 30) begin
            s = $urandom_range(0, 2);
            if (s == 0)
               push_req(OP_WRITE, range_addr(16'h0000, REG_ENABLE_END),
                        $urandom_range(0, 3) != 0 ? {4'($urandom), RAM_ENABLE_KEY} :
                                                    8'($urandom));
            else if (s == 1)
               push_req(OP_WRITE, range_addr(REG_ENABLE_END + 1, FIXED_ROM_END), 8'($urandom));
            else begin
               s = $urandom_range(0, 9);
               push_req(OP_WRITE, range_addr(FIXED_ROM_END + 1, REG_SELECT_END),
                        s < 5 ? 8'($urandom_range(SEL_SECONDS, SEL_DAY_HIGH)) :
                        s < 8 ? 8'($urandom_range(0, RAM_BANKS_MAX - 1)) : 8'($urandom));
            end
         end else if (r < 50) begin
            push_req(OP_READ, seeded_window_addr(), 8'($urandom));
         end else if (r < 62) begin
            push_req(OP_WRITE, $urandom_range(0, 1) ? seeded_window_addr() : window_addr(),
                     8'($urandom));
         end else if (r < 72) begin
            repeat ($urandom_range(1, 8)) push_req(OP_TICK, 16'($urandom), 8'($urandom));
         end else if (r < 80) begin
            clock_rollover_sequence();
         end else if (r < 90) begin
            if ($urandom_range(0, 2) != 0) latch_clock();
            else push_req(OP_WRITE, range_addr(REG_SELECT_END + 1, BANKED_ROM_END),
                          8'($urandom));
         end else begin
            // noise over the whole address space
            push_req(opcode_type'($urandom_range(0, 3)), 16'($urandom), 8'($urandom));
         end
      end
   endtask

   // reset, seed the ram, directed items, then random phases under several settings
   initial begin
      reset_cartridge_model();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      seed_ram();
      directed_items();
      wait_drained();
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:       load_settings(7, 2, 1, 1);
            1:       load_settings(0, 0, 0, 0);
            2:       load_settings(1, 3, 1, 1);
            3:       load_settings(7, 1, 0, 1);
            4:       load_settings(3, 0, 1, 0);
            default: load_settings($urandom_range(0, 7), $urandom_range(0, 3),
                                   $urandom_range(0, 1), $urandom_range(0, 1));
         endcase
         idle_on = (phase % 3 != 2);
         random_traffic(ITEMS_PER_PHASE);
         wait_drained();
      end
      repeat (8) @(posedge clock);
      if (bad_replies == 0 && bus_replies_due.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // watchdog
   initial begin
      #8000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

/* files.f */
rtl/cbc_pkg.sv
rtl/cbc_ram.sv
rtl/cbc_rtc.sv
rtl/cbc_ctrl.sv
rtl/cartridge_bank_controller_rtc_unit.sv
tb/sv/tb_cartridge_bank_controller_rtc_unit.sv
